[rtl/core/kalman_filter_two_state_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-state Kalman filter
// Implication checks, same-cycle and next-cycle, left out of synthesis.
// ----------------------------------------------------------------------------
`ifndef KALMAN_FILTER_TWO_STATE_MACROS_SVH
`define KALMAN_FILTER_TWO_STATE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KFTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kfts assertion failed");
// next-cycle implication
`define KFTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kfts assertion failed");
`else
`define KFTS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define KFTS_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/kfts_pkg.sv]
// ----------------------------------------------------------------------------
// kfts_pkg
// Shared constants, command and status types, and the micro-op program.
// ----------------------------------------------------------------------------
package kfts_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int PC_BITS       = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_VAR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_POS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_VEL  = 2'd2;

    // actions
    localparam logic [1:0] ACT_PREDICT = 2'd0;
    localparam logic [1:0] ACT_UPDATE  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_SKIP = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_HALF = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // operand and destination codes
    localparam logic [4:0] R_POS   = 5'd0;
    localparam logic [4:0] R_VEL   = 5'd1;
    localparam logic [4:0] R_P00   = 5'd2;
    localparam logic [4:0] R_P01   = 5'd3;
    localparam logic [4:0] R_P10   = 5'd4;
    localparam logic [4:0] R_P11   = 5'd5;
    localparam logic [4:0] R_DT    = 5'd6;
    localparam logic [4:0] R_RATE  = 5'd7;
    localparam logic [4:0] R_MEAS  = 5'd8;
    localparam logic [4:0] R_MVAR  = 5'd9;
    localparam logic [4:0] R_AV    = 5'd10;
    localparam logic [4:0] R_INITP = 5'd11;
    localparam logic [4:0] R_INITV = 5'd12;
    localparam logic [4:0] R_ONE   = 5'd13;
    localparam logic [4:0] R_FIFTY = 5'd14;
    localparam logic [4:0] R_ZERO  = 5'd15;
    localparam logic [4:0] R_T0    = 5'd16;
    localparam logic [4:0] R_T1    = 5'd17;
    localparam logic [4:0] R_T2    = 5'd18;
    localparam logic [4:0] R_T3    = 5'd19;
    localparam logic [4:0] R_N0    = 5'd20;
    localparam logic [4:0] R_N1    = 5'd21;
    localparam logic [4:0] R_N2    = 5'd22;
    localparam logic [4:0] R_N3    = 5'd23;

    // program entry points
    localparam logic [PC_BITS-1:0] PC_PREDICT = 6'd0;
    localparam logic [PC_BITS-1:0] PC_UPDATE  = 6'd29;
    localparam logic [PC_BITS-1:0] PC_RESTART = 6'd48;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic       chk;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic       start;
        logic       load_in;
        logic [2:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
        logic sat;
    } stat_t;

    // micro-op program; predict and update put the new covariance in N0..N3 and copy it at the end
    function automatic uop_t uop_rom(input logic [PC_BITS-1:0] pc);
        uop_t u;
        u = '{OP_ADD, R_ZERO, R_ZERO, R_T0, 1'b0, 1'b1};
        case (pc)
            // predict
            6'd0:  u = '{OP_MUL,  R_DT,    R_DT,   R_T0,  1'b0, 1'b0};
            6'd1:  u = '{OP_HALF, R_T0,    R_ZERO, R_T0,  1'b0, 1'b0};
            6'd2:  u = '{OP_MUL,  R_DT,    R_P10,  R_T1,  1'b0, 1'b0};
            6'd3:  u = '{OP_ADD,  R_P00,   R_T1,   R_T1,  1'b0, 1'b0};
            6'd4:  u = '{OP_MUL,  R_DT,    R_P11,  R_T2,  1'b0, 1'b0};
            6'd5:  u = '{OP_ADD,  R_P01,   R_T2,   R_T2,  1'b0, 1'b0};
            6'd6:  u = '{OP_MUL,  R_DT,    R_RATE, R_T3,  1'b0, 1'b0};
            6'd7:  u = '{OP_ADD,  R_POS,   R_T3,   R_POS, 1'b0, 1'b0};
            6'd8:  u = '{OP_ADD,  R_RATE,  R_ZERO, R_VEL, 1'b0, 1'b0};
            6'd9:  u = '{OP_MUL,  R_T2,    R_DT,   R_T3,  1'b0, 1'b0};
            6'd10: u = '{OP_ADD,  R_T1,    R_T3,   R_T1,  1'b0, 1'b0};
            6'd11: u = '{OP_MUL,  R_T0,    R_T0,   R_T3,  1'b0, 1'b0};
            6'd12: u = '{OP_MUL,  R_T3,    R_AV,   R_T3,  1'b0, 1'b0};
            6'd13: u = '{OP_ADD,  R_T1,    R_T3,   R_N0,  1'b0, 1'b0};
            6'd14: u = '{OP_MUL,  R_T0,    R_DT,   R_T3,  1'b0, 1'b0};
            6'd15: u = '{OP_MUL,  R_T3,    R_AV,   R_T3,  1'b0, 1'b0};
            6'd16: u = '{OP_ADD,  R_T2,    R_T3,   R_N1,  1'b0, 1'b0};
            6'd17: u = '{OP_MUL,  R_P11,   R_DT,   R_T1,  1'b0, 1'b0};
            6'd18: u = '{OP_ADD,  R_P10,   R_T1,   R_T1,  1'b0, 1'b0};
            6'd19: u = '{OP_MUL,  R_DT,    R_T0,   R_T3,  1'b0, 1'b0};
            6'd20: u = '{OP_MUL,  R_T3,    R_AV,   R_T3,  1'b0, 1'b0};
            6'd21: u = '{OP_ADD,  R_T1,    R_T3,   R_N2,  1'b0, 1'b0};
            6'd22: u = '{OP_MUL,  R_DT,    R_DT,   R_T3,  1'b0, 1'b0};
            6'd23: u = '{OP_MUL,  R_T3,    R_AV,   R_T3,  1'b0, 1'b0};
            6'd24: u = '{OP_ADD,  R_P11,   R_T3,   R_N3,  1'b0, 1'b0};
            6'd25: u = '{OP_ADD,  R_N0,    R_ZERO, R_P00, 1'b0, 1'b0};
            6'd26: u = '{OP_ADD,  R_N1,    R_ZERO, R_P01, 1'b0, 1'b0};
            6'd27: u = '{OP_ADD,  R_N2,    R_ZERO, R_P10, 1'b0, 1'b0};
            6'd28: u = '{OP_ADD,  R_N3,    R_ZERO, R_P11, 1'b0, 1'b1};
            // measurement update
            6'd29: u = '{OP_SUB,  R_MEAS,  R_POS,  R_T0,  1'b0, 1'b0};
            6'd30: u = '{OP_ADD,  R_P00,   R_MVAR, R_T1,  1'b1, 1'b0};
            6'd31: u = '{OP_DIV,  R_P00,   R_T1,   R_T2,  1'b0, 1'b0};
            6'd32: u = '{OP_DIV,  R_P10,   R_T1,   R_T3,  1'b0, 1'b0};
            6'd33: u = '{OP_MUL,  R_T2,    R_T0,   R_T1,  1'b0, 1'b0};
            6'd34: u = '{OP_ADD,  R_POS,   R_T1,   R_POS, 1'b0, 1'b0};
            6'd35: u = '{OP_MUL,  R_T3,    R_T0,   R_T1,  1'b0, 1'b0};
            6'd36: u = '{OP_ADD,  R_VEL,   R_T1,   R_VEL, 1'b0, 1'b0};
            6'd37: u = '{OP_SUB,  R_ONE,   R_T2,   R_T0,  1'b0, 1'b0};
            6'd38: u = '{OP_MUL,  R_T0,    R_P00,  R_N0,  1'b0, 1'b0};
            6'd39: u = '{OP_MUL,  R_T0,    R_P01,  R_N1,  1'b0, 1'b0};
            6'd40: u = '{OP_MUL,  R_T3,    R_P00,  R_T1,  1'b0, 1'b0};
            6'd41: u = '{OP_SUB,  R_P10,   R_T1,   R_N2,  1'b0, 1'b0};
            6'd42: u = '{OP_MUL,  R_T3,    R_P01,  R_T1,  1'b0, 1'b0};
            6'd43: u = '{OP_SUB,  R_P11,   R_T1,   R_N3,  1'b0, 1'b0};
            6'd44: u = '{OP_ADD,  R_N0,    R_ZERO, R_P00, 1'b0, 1'b0};
            6'd45: u = '{OP_ADD,  R_N1,    R_ZERO, R_P01, 1'b0, 1'b0};
            6'd46: u = '{OP_ADD,  R_N2,    R_ZERO, R_P10, 1'b0, 1'b0};
            6'd47: u = '{OP_ADD,  R_N3,    R_ZERO, R_P11, 1'b0, 1'b1};
            // restart
            6'd48: u = '{OP_ADD,  R_INITP, R_ZERO, R_POS, 1'b0, 1'b0};
            6'd49: u = '{OP_ADD,  R_INITV, R_ZERO, R_VEL, 1'b0, 1'b0};
            6'd50: u = '{OP_ADD,  R_ONE,   R_ZERO, R_P00, 1'b0, 1'b0};
            6'd51: u = '{OP_ADD,  R_ZERO,  R_ZERO, R_P01, 1'b0, 1'b0};
            6'd52: u = '{OP_ADD,  R_ZERO,  R_ZERO, R_P10, 1'b0, 1'b0};
            6'd53: u = '{OP_ADD,  R_FIFTY, R_ZERO, R_P11, 1'b0, 1'b1};
            default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T0, 1'b0, 1'b1};
        endcase
        return u;
    endfunction

endpackage

[rtl/core/kfts_channels.sv]
// ----------------------------------------------------------------------------
// kfts channels
// Valid/ready interfaces for the sample word and the estimate word.
// ----------------------------------------------------------------------------
interface kfts_in_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [WORD_BITS-2:0]        time_step;
    logic signed [WORD_BITS-1:0] gyro_rate;
    logic signed [WORD_BITS-1:0] measurement;
    logic [WORD_BITS-2:0]        measurement_variance;

    modport source (output valid, action, time_step, gyro_rate, measurement,
                    measurement_variance, input ready);
    modport sink   (input valid, action, time_step, gyro_rate, measurement,
                    measurement_variance, output ready);
endinterface

interface kfts_out_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] position;
    logic signed [WORD_BITS-1:0] velocity;
    logic signed [WORD_BITS-1:0] position_variance;
    logic signed [WORD_BITS-1:0] cross_covariance;
    logic signed [WORD_BITS-1:0] velocity_variance;
    logic [1:0]                  status;

    modport source (output valid, position, velocity, position_variance,
                    cross_covariance, velocity_variance, status, input ready);
    modport sink   (input valid, position, velocity, position_variance,
                    cross_covariance, velocity_variance, status, output ready);
endinterface

[rtl/core/kfts_ctrl.sv]
// ----------------------------------------------------------------------------
// kfts_ctrl
// Sequencer: accepts a word, steps the micro-op program, hands off the result.
// ----------------------------------------------------------------------------
`include "kalman_filter_two_state_macros.svh"

module kfts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_action,
    output logic           in_ready,
    output kfts_pkg::cmd_t cmd,
    input  kfts_pkg::stat_t stat,
    input  logic           out_free,
    output logic           load_out,
    output logic [1:0]     status
);
    import kfts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               skip_reg, skip_next;
    logic               accept;
    uop_t               uop;

    assign uop      = uop_rom(pc_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign status   = skip_reg ? STATUS_SKIP : (stat.sat ? STATUS_SAT : STATUS_OK);

    // issue the current micro-op
    always_comb
    begin
        cmd.start   = (state_reg == ST_RUN);
        cmd.load_in = accept;
        cmd.op      = uop.op;
        cmd.src_a   = uop.src_a;
        cmd.src_b   = uop.src_b;
        cmd.dst     = uop.dst;
    end

    // sequence the program
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        skip_next  = skip_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    skip_next = 1'b0;
                    case (in_action)
                        ACT_PREDICT:
                        begin
                            pc_next    = PC_PREDICT;
                            state_next = ST_RUN;
                        end
                        ACT_UPDATE:
                        begin
                            pc_next    = PC_UPDATE;
                            state_next = ST_RUN;
                        end
                        ACT_RESTART:
                        begin
                            pc_next    = PC_RESTART;
                            state_next = ST_RUN;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RUN: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    if (uop.chk && stat.zero)
                    begin
                        skip_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (uop.last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            skip_reg  <= skip_next;
        end
    end

    `KFTS_ASSERT_IMP(a_start_when_free, clk, rst_n, cmd.start, !stat.busy)
    `KFTS_ASSERT_IMP(a_done_in_wait, clk, rst_n, stat.done, state_reg == ST_WAIT)
    `KFTS_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != ST_IDLE)

endmodule

[rtl/core/kfts_dpath.sv]
// ----------------------------------------------------------------------------
// kfts_dpath
// State, scratch registers and one shared execution unit: saturating add,
// subtract and halve, bit-serial multiply and restoring divide.
// ----------------------------------------------------------------------------
`include "kalman_filter_two_state_macros.svh"

module kfts_dpath #(
    parameter int WORD_BITS = kfts_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = kfts_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kfts_pkg::cmd_t                    cmd,
    output kfts_pkg::stat_t                   stat,
    input  logic [WORD_BITS-2:0]              time_step,
    input  logic [WORD_BITS-1:0]              gyro_rate,
    input  logic [WORD_BITS-1:0]              measurement,
    input  logic [WORD_BITS-2:0]              measurement_variance,
    input  logic                              cfg_we,
    input  logic [kfts_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]              cfg_data,
    output logic [WORD_BITS-1:0]              position,
    output logic [WORD_BITS-1:0]              velocity,
    output logic [WORD_BITS-1:0]              position_variance,
    output logic [WORD_BITS-1:0]              cross_covariance,
    output logic [WORD_BITS-1:0]              velocity_variance
);
    import kfts_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int QW    = 2 * WORD_BITS;
    localparam int NW    = WORD_BITS + FRAC_BITS;
    localparam int CW    = $clog2(WORD_BITS + FRAC_BITS + 1);
    localparam int CWIDE = WORD_BITS + FRAC_BITS + 7;

    localparam logic [CWIDE-1:0] VMAX_WIDE  = (CWIDE'(1) << (W - 1)) - CWIDE'(1);
    localparam logic [CWIDE-1:0] ONE_WIDE   = CWIDE'(1) << F;
    localparam logic [CWIDE-1:0] FIFTY_WIDE = CWIDE'(50) << F;
    localparam bit               ONE_SAT    = (ONE_WIDE > VMAX_WIDE);
    localparam bit               FIFTY_SAT  = (FIFTY_WIDE > VMAX_WIDE);
    localparam logic [W-1:0]     ONE_Q      = ONE_SAT ? VMAX_WIDE[W-1:0] : ONE_WIDE[W-1:0];
    localparam logic [W-1:0]     FIFTY_Q    = FIFTY_SAT ? VMAX_WIDE[W-1:0] : FIFTY_WIDE[W-1:0];
    localparam logic [W-1:0]     MAX_Q      = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     MIN_Q      = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0]    LIM_POS    = {{W{1'b0}}, MAX_Q};
    localparam logic [QW-1:0]    LIM_NEG    = {{W{1'b0}}, MIN_Q};

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EXEC = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    // magnitude of a signed word, as an unsigned word
    function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    // filter state
    logic [W-1:0] pos_reg, vel_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    // scratch
    logic [W-1:0] t0_reg, t1_reg, t2_reg, t3_reg, n0_reg, n1_reg, n2_reg, n3_reg;
    // latched word and configuration
    logic [W-2:0] dt_reg, mvar_reg, av_reg;
    logic [W-1:0] rate_reg, meas_reg, initp_reg, initv_reg;
    // execution unit
    logic [1:0]    phase_reg;
    logic [2:0]    op_reg;
    logic [4:0]    dst_reg;
    logic [W-1:0]  a_reg, b_reg, ua_reg, hi_reg, lo_reg, ud_reg, rem_reg;
    logic [NW-1:0] nq_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg, sat_reg;

    logic [W-1:0]  a_src, b_src;
    logic          const_sat;
    logic [W:0]    sum_w, diff_w;
    logic [W-1:0]  alu_res, fin_m, fin_res, res;
    logic          alu_sat, fin_sat, res_sat, is_alu, done;
    logic [W:0]    mul_sum;
    logic [W-1:0]  div_r2, div_rem;
    logic          div_ge;
    logic [QW-1:0] fin_q, fin_lim;

    // select operand A
    always_comb
    begin
        case (cmd.src_a)
            R_POS:   a_src = pos_reg;
            R_VEL:   a_src = vel_reg;
            R_P00:   a_src = p00_reg;
            R_P01:   a_src = p01_reg;
            R_P10:   a_src = p10_reg;
            R_P11:   a_src = p11_reg;
            R_DT:    a_src = {1'b0, dt_reg};
            R_RATE:  a_src = rate_reg;
            R_MEAS:  a_src = meas_reg;
            R_MVAR:  a_src = {1'b0, mvar_reg};
            R_AV:    a_src = {1'b0, av_reg};
            R_INITP: a_src = initp_reg;
            R_INITV: a_src = initv_reg;
            R_ONE:   a_src = ONE_Q;
            R_FIFTY: a_src = FIFTY_Q;
            R_T0:    a_src = t0_reg;
            R_T1:    a_src = t1_reg;
            R_T2:    a_src = t2_reg;
            R_T3:    a_src = t3_reg;
            R_N0:    a_src = n0_reg;
            R_N1:    a_src = n1_reg;
            R_N2:    a_src = n2_reg;
            R_N3:    a_src = n3_reg;
            default: a_src = '0;
        endcase
    end

    // select operand B
    always_comb
    begin
        case (cmd.src_b)
            R_POS:   b_src = pos_reg;
            R_VEL:   b_src = vel_reg;
            R_P00:   b_src = p00_reg;
            R_P01:   b_src = p01_reg;
            R_P10:   b_src = p10_reg;
            R_P11:   b_src = p11_reg;
            R_DT:    b_src = {1'b0, dt_reg};
            R_RATE:  b_src = rate_reg;
            R_MEAS:  b_src = meas_reg;
            R_MVAR:  b_src = {1'b0, mvar_reg};
            R_AV:    b_src = {1'b0, av_reg};
            R_INITP: b_src = initp_reg;
            R_INITV: b_src = initv_reg;
            R_ONE:   b_src = ONE_Q;
            R_FIFTY: b_src = FIFTY_Q;
            R_T0:    b_src = t0_reg;
            R_T1:    b_src = t1_reg;
            R_T2:    b_src = t2_reg;
            R_T3:    b_src = t3_reg;
            R_N0:    b_src = n0_reg;
            R_N1:    b_src = n1_reg;
            R_N2:    b_src = n2_reg;
            R_N3:    b_src = n3_reg;
            default: b_src = '0;
        endcase
    end

    // constants that do not fit count as saturation when read
    assign const_sat = (ONE_SAT && (cmd.src_a == R_ONE || cmd.src_b == R_ONE)) ||
                       (FIFTY_SAT && (cmd.src_a == R_FIFTY || cmd.src_b == R_FIFTY));

    // saturating add and subtract, and arithmetic halve
    assign sum_w  = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
    assign diff_w = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
    assign is_alu = (op_reg == OP_ADD) || (op_reg == OP_SUB) || (op_reg == OP_HALF);

    always_comb
    begin
        alu_sat = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                alu_sat = (sum_w[W] != sum_w[W-1]);
                alu_res = alu_sat ? (sum_w[W] ? MIN_Q : MAX_Q) : sum_w[W-1:0];
            end
            OP_SUB:
            begin
                alu_sat = (diff_w[W] != diff_w[W-1]);
                alu_res = alu_sat ? (diff_w[W] ? MIN_Q : MAX_Q) : diff_w[W-1:0];
            end
            OP_HALF: alu_res = {a_reg[W-1], a_reg[W-1:1]};
            default: alu_res = a_reg;
        endcase
    end

    // one multiply bit and one quotient bit per step
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ua_reg} : {(W+1){1'b0}});
    assign div_r2  = {rem_reg[W-2:0], nq_reg[NW-1]};
    assign div_ge  = (div_r2 >= ud_reg);
    assign div_rem = div_ge ? (div_r2 - ud_reg) : div_r2;

    // scale, clamp and sign the magnitude
    assign fin_q   = (op_reg == OP_MUL) ? ({hi_reg, lo_reg} >> F) : QW'(nq_reg);
    assign fin_lim = neg_reg ? LIM_NEG : LIM_POS;
    assign fin_sat = (fin_q > fin_lim);
    assign fin_m   = fin_sat ? fin_lim[W-1:0] : fin_q[W-1:0];
    assign fin_res = neg_reg ? (~fin_m + 1'b1) : fin_m;

    assign done    = ((phase_reg == PH_EXEC) && is_alu) || (phase_reg == PH_FIN);
    assign res     = (phase_reg == PH_FIN) ? fin_res : alu_res;
    assign res_sat = (phase_reg == PH_FIN) ? fin_sat : alu_sat;

    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = done;
    assign stat.zero = (res == '0);
    assign stat.sat  = sat_reg;

    assign position          = pos_reg;
    assign velocity          = vel_reg;
    assign position_variance = p00_reg;
    assign cross_covariance  = p01_reg;
    assign velocity_variance = p11_reg;

    // advance the execution phase and collect saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                sat_reg <= 1'b0;
            end
            else if (cmd.start)
            begin
                sat_reg <= sat_reg | const_sat;
            end
            else if (done)
            begin
                sat_reg <= sat_reg | res_sat;
            end
            case (phase_reg)
                PH_IDLE: if (cmd.start) phase_reg <= PH_EXEC;
                PH_EXEC: phase_reg <= is_alu ? PH_IDLE : PH_ITER;
                PH_ITER: if (cnt_reg == CW'(1)) phase_reg <= PH_FIN;
                PH_FIN:  phase_reg <= PH_IDLE;
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    // operand latch, set-up and iteration
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= a_src;
            b_reg   <= b_src;
            op_reg  <= cmd.op;
            dst_reg <= cmd.dst;
        end
        if (phase_reg == PH_EXEC)
        begin
            neg_reg <= a_reg[W-1] ^ b_reg[W-1];
            ua_reg  <= mag_of(a_reg);
            lo_reg  <= mag_of(b_reg);
            hi_reg  <= '0;
            ud_reg  <= mag_of(b_reg);
            rem_reg <= '0;
            nq_reg  <= {mag_of(a_reg), {F{1'b0}}};
            cnt_reg <= (op_reg == OP_MUL) ? CW'(W) : CW'(NW);
        end
        if (phase_reg == PH_ITER)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (op_reg == OP_MUL)
            begin
                hi_reg <= mul_sum[W:1];
                lo_reg <= {mul_sum[0], lo_reg[W-1:1]};
            end
            else
            begin
                rem_reg <= div_rem;
                nq_reg  <= {nq_reg[NW-2:0], div_ge};
            end
        end
    end

    // write back filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            p00_reg <= ONE_Q;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= FIFTY_Q;
        end
        else if (done)
        begin
            case (dst_reg)
                R_POS:   pos_reg <= res;
                R_VEL:   vel_reg <= res;
                R_P00:   p00_reg <= res;
                R_P01:   p01_reg <= res;
                R_P10:   p10_reg <= res;
                R_P11:   p11_reg <= res;
                default: ;
            endcase
        end
    end

    // write back scratch registers
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            case (dst_reg)
                R_T0:    t0_reg <= res;
                R_T1:    t1_reg <= res;
                R_T2:    t2_reg <= res;
                R_T3:    t3_reg <= res;
                R_N0:    n0_reg <= res;
                R_N1:    n1_reg <= res;
                R_N2:    n2_reg <= res;
                R_N3:    n3_reg <= res;
                default: ;
            endcase
        end
    end

    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dt_reg   <= time_step;
            rate_reg <= gyro_rate;
            meas_reg <= measurement;
            mvar_reg <= measurement_variance;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg    <= '0;
            initp_reg <= '0;
            initv_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEL_VAR: av_reg    <= cfg_data[W-2:0];
                CFG_INIT_POS:  initp_reg <= cfg_data;
                CFG_INIT_VEL:  initv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    `KFTS_ASSERT_NXT(a_done_frees_unit, clk, rst_n, done, phase_reg == PH_IDLE)
    `KFTS_ASSERT_IMP(a_iter_count_live, clk, rst_n, phase_reg == PH_ITER, cnt_reg != '0)
    `KFTS_ASSERT_IMP(a_no_start_busy, clk, rst_n, cmd.start, phase_reg == PH_IDLE)

endmodule

[rtl/core/kalman_filter_two_state.sv]
// ----------------------------------------------------------------------------
// kalman_filter_two_state
// Two-state (position, velocity) Kalman filter in signed fixed point.
// ----------------------------------------------------------------------------
// One word in, one estimate word out, one word at a time. Every arithmetic
// step runs on a single shared unit: add, subtract and halve, a bit-serial
// multiply and a restoring divide (one quotient bit per cycle). Predict is 14
// multiplies and 15 short ops; words are Q16.16 with the default parameters.
// The next sample word is taken as soon as the estimate sits in the output
// register.
module kalman_filter_two_state #(
    parameter int WORD_BITS = kfts_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = kfts_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    kfts_in_if.sink                           sample,
    kfts_out_if.source                        estimate,
    input  logic                              cfg_we,
    input  logic [kfts_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]              cfg_data
);
    import kfts_pkg::*;

    cmd_t                 cmd;
    stat_t                stat;
    logic                 out_free, load_out;
    logic [1:0]           status;
    logic [WORD_BITS-1:0] pos, vel, p00, p01, p11;

    logic                 valid_reg;
    logic [WORD_BITS-1:0] pos_reg, vel_reg, p00_reg, p01_reg, p11_reg;
    logic [1:0]           status_reg;

    kfts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_action (sample.action),
        .in_ready  (sample.ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_free  (out_free),
        .load_out  (load_out),
        .status    (status)
    );

    kfts_dpath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .time_step            (sample.time_step),
        .gyro_rate            (sample.gyro_rate),
        .measurement          (sample.measurement),
        .measurement_variance (sample.measurement_variance),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .position             (pos),
        .velocity             (vel),
        .position_variance    (p00),
        .cross_covariance     (p01),
        .velocity_variance    (p11)
    );

    assign out_free = !valid_reg || estimate.ready;

    // output register: hold the estimate word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            valid_reg <= 1'b1;
        end
        else if (estimate.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pos_reg    <= pos;
            vel_reg    <= vel;
            p00_reg    <= p00;
            p01_reg    <= p01;
            p11_reg    <= p11;
            status_reg <= status;
        end
    end

    assign estimate.valid             = valid_reg;
    assign estimate.position          = pos_reg;
    assign estimate.velocity          = vel_reg;
    assign estimate.position_variance = p00_reg;
    assign estimate.cross_covariance  = p01_reg;
    assign estimate.velocity_variance = p11_reg;
    assign estimate.status            = status_reg;

endmodule
